// File: hw/rtl/qvt_pkg.sv
// Shared types and constants for the quaternion vertex transform.
// Used by qvt_derive, qvt_front, qvt_back and the top level; no dependencies.
package qvt_pkg;

	localparam int Q14_ONE    = 16384;
	localparam int ROUND_HALF = 8192;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ROT_W     = 3'd0,
		REG_ROT_X     = 3'd1,
		REG_ROT_Y     = 3'd2,
		REG_ROT_Z     = 3'd3,
		REG_SHIFT_X   = 3'd4,
		REG_SHIFT_Y   = 3'd5,
		REG_SHIFT_Z   = 3'd6,
		REG_AXIS_THR  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic               last_vertex;
	} vtx_in_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               last_out;
	} vtx_out_t;

	// derived rotation terms and translation handed to the datapath
	typedef struct packed {
		logic signed [15:0] ux;
		logic signed [15:0] uy;
		logic signed [15:0] uz;
		logic signed [15:0] cos_a;
		logic signed [15:0] sin_a;
		logic               rot_en;
		logic signed [31:0] sh_x;
		logic signed [31:0] sh_y;
		logic signed [31:0] sh_z;
	} xform_t;

	// queue entry: vertex tagged with its rotate/translate class
	typedef struct packed {
		vtx_in_t vtx;
		logic    rot;
	} qitem_t;

endpackage

// File: hw/rtl/quaternion_vertex_transform_unit.sv
// Quaternion vertex transform: rotate each vertex about a configured axis, then translate.
// Channels: vtx (vtx_valid, vtx_stall, vtx) in, res (res_valid, res_stall, res) out.
// A beat moves at a rising edge with valid high and stall low.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 rot_w .. 7 threshold).
// Each write starts a rebuild of unit axis, cos and sin (5 squaring steps,
// 16 square-root steps, 30 division steps, one final step); vtx_stall stays high
// throughout. Write only while no vertex is in flight.
// Throughput: one vertex per cycle unless res_stall or a rebuild holds the flow.
// Path from an accepted vtx beat to res_valid with an empty queue: queue write at the
// accepting edge, then five datapath stages and the result register.
// A 4-entry queue sits between input and datapath; a res_stall on a valid result
// freezes the datapath and the queue fills before vtx_stall rises.
// Reset clears the queue and pipeline valids and loads the reset rotation terms
// (identity, rotation off), so no rebuild runs after reset.
// Depends on qvt_pkg, qvt_derive, qvt_front, qvt_back.
module quaternion_vertex_transform_unit import qvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        vtx_valid,
	output logic        vtx_stall,
	input  vtx_in_t     vtx,
	output logic        res_valid,
	input  logic        res_stall,
	output vtx_out_t    res
);

	xform_t xf;
	logic   busy;
	logic   q_valid;
	qitem_t q_item;
	logic   q_pop;

	qvt_derive u_derive (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.xf        (xf),
		.busy      (busy)
	);

	qvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.busy      (busy),
		.rot_en    (xf.rot_en),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	qvt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.xf        (xf),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// File: hw/rtl/qvt_derive.sv
// Configuration registers and the sequencer that derives unit axis, cos and sin.
// Depends on qvt_pkg.
module qvt_derive import qvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output xform_t      xf,
	output logic        busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SQ   = 5'b00010,
		ST_ROOT = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} seq_st_t;

	seq_st_t            state_q;
	logic [4:0]         cnt_q;
	logic signed [15:0] rot_q [4];
	logic signed [31:0] sh_q [3];
	logic [14:0]        thr_q;
	logic [31:0]        acc_q;
	logic [30:0]        wsq_q;
	logic [31:0]        sa_v_q, sa_r_q, sb_v_q, sb_r_q, bit_q;
	logic [17:0]        rem_q [3];
	logic [29:0]        dq_q [3];
	logic signed [15:0] unit_q [3];
	logic signed [15:0] cos_q, sin_q;
	logic               rot_en_q;

	logic signed [15:0] sq_op;
	logic signed [31:0] sq_prod;
	logic [63:0]        sa_nx, sb_nx;
	logic [16:0]        magn;
	logic [17:0]        dsh [3];
	logic               dge [3];
	logic [32:0]        cos_t;
	logic signed [19:0] cos_r;
	logic signed [32:0] sin_p;
	logic signed [34:0] sin_t;
	logic signed [20:0] sin_r;

	// one step of the bitwise square root: returns {value, root}
	function automatic logic [63:0] isq_step(input logic [31:0] v, input logic [31:0] r,
			input logic [31:0] b);
		logic [32:0] t;
		t = {1'b0, r} + {1'b0, b};
		if ({1'b0, v} >= t) begin
			return {v - t[31:0], (r >> 1) + b};
		end
		return {v, r >> 1};
	endfunction

	// register writes; unused upper bits of the narrow registers drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 16'sd16384;
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
			sh_q[0]  <= '0;
			sh_q[1]  <= '0;
			sh_q[2]  <= '0;
			thr_q    <= 15'd16;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROT_W:    rot_q[0] <= cfg_wdata[15:0];
				REG_ROT_X:    rot_q[1] <= cfg_wdata[15:0];
				REG_ROT_Y:    rot_q[2] <= cfg_wdata[15:0];
				REG_ROT_Z:    rot_q[3] <= cfg_wdata[15:0];
				REG_SHIFT_X:  sh_q[0]  <= cfg_wdata;
				REG_SHIFT_Y:  sh_q[1]  <= cfg_wdata;
				REG_SHIFT_Z:  sh_q[2]  <= cfg_wdata;
				REG_AXIS_THR: thr_q    <= cfg_wdata[14:0];
				default:      thr_q    <= thr_q;
			endcase
		end
	end

	// shared squaring multiplier: x, y, z, then w
	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sq_op = rot_q[1];
			2'd1:    sq_op = rot_q[2];
			2'd2:    sq_op = rot_q[3];
			default: sq_op = rot_q[0];
		endcase
	end
	assign sq_prod = sq_op * sq_op;

	assign sa_nx = isq_step(sa_v_q, sa_r_q, bit_q);
	assign sb_nx = isq_step(sb_v_q, sb_r_q, bit_q);
	assign magn  = sa_r_q[16:0];

	// restoring division lanes, one quotient bit per cycle
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dsh[i] = {rem_q[i][16:0], dq_q[i][29]};
			dge[i] = dsh[i] >= {1'b0, magn};
		end
	end

	// cos = 2w^2 - 1, sin = 2w*sqrt(1 - w^2), both rounded and saturated
	assign cos_t = {1'b0, wsq_q, 1'b0} + 33'(ROUND_HALF);
	assign cos_r = $signed({1'b0, cos_t[32:14]}) - 20'sd16384;
	assign sin_p = rot_q[0] * $signed({1'b0, sb_r_q[15:0]});
	assign sin_t = {sin_p[32], sin_p, 1'b0} + 35'sd8192;
	assign sin_r = sin_t[34:14];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			unit_q[0] <= '0;
			unit_q[1] <= '0;
			unit_q[2] <= '0;
			cos_q    <= 16'sd16384;
			sin_q    <= '0;
			rot_en_q <= 1'b0;
		end else if (cfg_we) begin
			state_q <= ST_SQ;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd4) begin
						state_q <= ST_ROOT;
						cnt_q   <= '0;
					end
				end
				ST_ROOT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd29) begin
						state_q <= ST_FIN;
						cnt_q   <= '0;
					end
				end
				ST_FIN: begin
					state_q <= ST_IDLE;
					for (int i = 0; i < 3; i++) begin
						if (magn == '0) begin
							unit_q[i] <= '0;
						end else if (rot_q[i + 1] < 0) begin
							unit_q[i] <= -$signed(dq_q[i][15:0]);
						end else begin
							unit_q[i] <= $signed(dq_q[i][15:0]);
						end
					end
					cos_q    <= (cos_r > 20'sd32767) ? 16'sd32767 : cos_r[15:0];
					sin_q    <= (sin_r > 21'sd32767) ? 16'sd32767 :
						(sin_r < -21'sd32768) ? -16'sd32768 : sin_r[15:0];
					rot_en_q <= magn > {2'b0, thr_q};
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SQ: begin
				if (cnt_q == 5'd0) begin
					acc_q <= sq_prod[31:0];
				end else if (cnt_q < 5'd3) begin
					acc_q <= acc_q + sq_prod[31:0];
				end else if (cnt_q == 5'd3) begin
					wsq_q <= sq_prod[30:0];
				end else begin
					sa_v_q <= acc_q;
					sa_r_q <= '0;
					sb_v_q <= (wsq_q < 31'd268435456) ? 32'd268435456 - {1'b0, wsq_q} : '0;
					sb_r_q <= '0;
					bit_q  <= 32'h4000_0000;
				end
			end
			ST_ROOT: begin
				sa_v_q <= sa_nx[63:32];
				sa_r_q <= sa_nx[31:0];
				sb_v_q <= sb_nx[63:32];
				sb_r_q <= sb_nx[31:0];
				bit_q  <= bit_q >> 2;
				if (cnt_q == 5'd15) begin
					for (int i = 0; i < 3; i++) begin
						rem_q[i] <= '0;
						dq_q[i]  <= {(rot_q[i + 1] < 0) ? 16'(-rot_q[i + 1]) : rot_q[i + 1],
							14'd0};
					end
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 3; i++) begin
					rem_q[i] <= dge[i] ? dsh[i] - {1'b0, magn} : dsh[i];
					dq_q[i]  <= {dq_q[i][28:0], dge[i]};
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign busy      = state_q != ST_IDLE;
	assign xf.ux     = unit_q[0];
	assign xf.uy     = unit_q[1];
	assign xf.uz     = unit_q[2];
	assign xf.cos_a  = cos_q;
	assign xf.sin_a  = sin_q;
	assign xf.rot_en = rot_en_q;
	assign xf.sh_x   = sh_q[0];
	assign xf.sh_y   = sh_q[1];
	assign xf.sh_z   = sh_q[2];

endmodule

// File: hw/rtl/qvt_front.sv
// Input side: accepts vertex beats, tags them rotate or translate, queues them.
// Depends on qvt_pkg.
module qvt_front import qvt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    vtx_valid,
	output logic    vtx_stall,
	input  vtx_in_t vtx,
	input  logic    busy,
	input  logic    rot_en,
	output logic    q_valid,
	output qitem_t  q_item,
	input  logic    q_pop
);

	qitem_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;

	// hold input while the queue is full or the rotation terms are rebuilt
	assign vtx_stall = (cnt_q == (QPTR_W + 1)'(QDEPTH)) || busy;
	assign push      = vtx_valid && !vtx_stall;
	assign q_valid   = cnt_q != '0;
	assign q_item    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{vtx: vtx, rot: rot_en};
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/qvt_back.sv
// Rodrigues rotation and translation datapath with the result register.
// Depends on qvt_pkg.
module qvt_back import qvt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_valid,
	input  qitem_t   q_item,
	output logic     q_pop,
	input  xform_t   xf,
	output logic     res_valid,
	input  logic     res_stall,
	output vtx_out_t res
);

	logic signed [15:0] u [3];
	logic signed [31:0] vin [3];
	logic signed [31:0] sh [3];

	logic               adv;
	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, res_vld_q;
	logic               last_s1, last_s2, last_s3, last_s4, last_s5;
	logic               rot_s1, rot_s2, rot_s3, rot_s4, rot_s5;
	logic signed [31:0] v_s1 [3], v_s2 [3], v_s3 [3], v_s4 [3], v_s5 [3];
	logic signed [47:0] md_s1 [3];
	logic signed [47:0] mc_s1 [6];
	logic signed [35:0] d_s2;
	logic signed [35:0] c_s2 [3], c_s3 [3], c_s4 [3];
	logic signed [51:0] pm_s3 [3];
	logic signed [37:0] p_s4 [3], p_s5 [3];
	logic signed [38:0] q_s4 [3];
	logic signed [54:0] cq_s5 [3];
	logic signed [51:0] sc_s5 [3];
	vtx_out_t           res_q;

	logic signed [49:0] dsum;
	logic signed [48:0] cdif [3];
	logic signed [51:0] pm_r [3];
	logic signed [54:0] cq_r [3];
	logic signed [51:0] sc_r [3];
	logic signed [43:0] tot [3];
	logic signed [31:0] sat_o [3];

	assign u[0]   = xf.ux;
	assign u[1]   = xf.uy;
	assign u[2]   = xf.uz;
	assign sh[0]  = xf.sh_x;
	assign sh[1]  = xf.sh_y;
	assign sh[2]  = xf.sh_z;
	assign vin[0] = q_item.vtx.vertex_x;
	assign vin[1] = q_item.vtx.vertex_y;
	assign vin[2] = q_item.vtx.vertex_z;

	// the whole pipe moves unless the result register is held
	assign adv   = !res_vld_q || !res_stall;
	assign q_pop = adv && q_valid;

	// rounding of the dot, cross and projection sums, then the final sum with shift and saturation
	always_comb begin
		dsum = 50'(md_s1[0]) + 50'(md_s1[1]) + 50'(md_s1[2]) + 50'sd8192;
		cdif[0] = 49'(mc_s1[0]) - 49'(mc_s1[1]) + 49'sd8192;
		cdif[1] = 49'(mc_s1[2]) - 49'(mc_s1[3]) + 49'sd8192;
		cdif[2] = 49'(mc_s1[4]) - 49'(mc_s1[5]) + 49'sd8192;
		for (int i = 0; i < 3; i++) begin
			pm_r[i] = pm_s3[i] + 52'sd8192;
			cq_r[i] = cq_s5[i] + 55'sd8192;
			sc_r[i] = sc_s5[i] + 52'sd8192;
			if (rot_s5) begin
				tot[i] = 44'(p_s5[i]) + 44'($signed(cq_r[i][54:14]))
					+ 44'($signed(sc_r[i][51:14])) + 44'(sh[i]);
			end else begin
				tot[i] = 44'(v_s5[i]) + 44'(sh[i]);
			end
			if (tot[i] > 44'sd2147483647) begin
				sat_o[i] = 32'sh7fff_ffff;
			end else if (tot[i] < -44'sd2147483648) begin
				sat_o[i] = 32'sh8000_0000;
			end else begin
				sat_o[i] = tot[i][31:0];
			end
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			res_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1    <= q_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			res_vld_q <= vld_s5;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: dot and cross partial products
			for (int i = 0; i < 3; i++) begin
				md_s1[i] <= u[i] * vin[i];
			end
			mc_s1[0] <= u[1] * vin[2];
			mc_s1[1] <= u[2] * vin[1];
			mc_s1[2] <= u[2] * vin[0];
			mc_s1[3] <= u[0] * vin[2];
			mc_s1[4] <= u[0] * vin[1];
			mc_s1[5] <= u[1] * vin[0];
			v_s1     <= vin;
			last_s1  <= q_item.vtx.last_vertex;
			rot_s1   <= q_item.rot;
			// s2: rounded dot product and cross product
			d_s2 <= dsum[49:14];
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= 36'($signed(cdif[i][48:14]));
			end
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			rot_s2  <= rot_s1;
			// s3: projection onto the axis
			for (int i = 0; i < 3; i++) begin
				pm_s3[i] <= u[i] * d_s2;
			end
			c_s3    <= c_s2;
			v_s3    <= v_s2;
			last_s3 <= last_s2;
			rot_s3  <= rot_s2;
			// s4: parallel and perpendicular parts
			for (int i = 0; i < 3; i++) begin
				p_s4[i] <= pm_r[i][51:14];
				q_s4[i] <= 39'(v_s3[i]) - 39'($signed(pm_r[i][51:14]));
			end
			c_s4    <= c_s3;
			v_s4    <= v_s3;
			last_s4 <= last_s3;
			rot_s4  <= rot_s3;
			// s5: cos and sin weighting
			for (int i = 0; i < 3; i++) begin
				cq_s5[i] <= xf.cos_a * q_s4[i];
				sc_s5[i] <= xf.sin_a * c_s4[i];
			end
			p_s5    <= p_s4;
			v_s5    <= v_s4;
			last_s5 <= last_s4;
			rot_s5  <= rot_s4;
			// result register: sum, translate, saturate
			res_q.out_x    <= sat_o[0];
			res_q.out_y    <= sat_o[1];
			res_q.out_z    <= sat_o[2];
			res_q.last_out <= last_s5;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

// File: dv/qvt_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the quaternion vertex transform: tracks configuration writes,
// predicts each transformed vertex and compares it on the result channel. Uses qvt_pkg.
module qvt_checker import qvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	input  logic        vtx_valid,
	input  logic        vtx_stall,
	input  vtx_in_t     vtx,
	input  logic        res_valid,
	input  logic        res_stall,
	input  vtx_out_t    res,
	output int          fail_count,
	output int          pending
);

	// shadow registers
	logic signed [15:0] q_w, q_x, q_y, q_z;
	logic signed [31:0] sh_x, sh_y, sh_z;
	logic        [14:0] thr;

	// rotation terms rebuilt after each write
	logic signed [15:0] axis_u [3];
	logic signed [15:0] cos_q, sin_q;
	logic               rot_on;

	vtx_out_t expected_q [$];

	function automatic longint round14(longint v);
		return (v + 8192) >>> 14;
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint unsigned r, b, x;
		r = 0;
		x = v;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void rebuild_terms();
		longint comp [3];
		longint magn, wsq, root;
		comp[0] = q_x;
		comp[1] = q_y;
		comp[2] = q_z;
		magn = floor_sqrt(comp[0] * comp[0] + comp[1] * comp[1] + comp[2] * comp[2]);
		for (int i = 0; i < 3; i++)
			axis_u[i] = (magn != 0) ? 16'((comp[i] * Q14_ONE) / magn) : 16'sd0;
		rot_on = magn > longint'(thr);
		wsq = longint'(q_w) * q_w;
		cos_q = 16'(clamp(round14(2 * wsq) - Q14_ONE, -32768, 32767));
		root = 0;
		// scalar at or beyond one: no sine term
		if (wsq < (64'sd1 << 28))
			root = floor_sqrt((64'sd1 << 28) - wsq);
		sin_q = 16'(clamp(round14(2 * longint'(q_w) * root), -32768, 32767));
	endfunction

	function automatic vtx_out_t transform_vertex(vtx_in_t vi);
		longint v [3], u [3], c [3], outv [3];
		longint d, p, q, sh [3];
		vtx_out_t r;
		v[0] = vi.vertex_x;
		v[1] = vi.vertex_y;
		v[2] = vi.vertex_z;
		sh[0] = sh_x;
		sh[1] = sh_y;
		sh[2] = sh_z;
		for (int i = 0; i < 3; i++)
			u[i] = axis_u[i];
		if (rot_on) begin
			d = round14(u[0] * v[0] + u[1] * v[1] + u[2] * v[2]);
			c[0] = round14(u[1] * v[2] - u[2] * v[1]);
			c[1] = round14(u[2] * v[0] - u[0] * v[2]);
			c[2] = round14(u[0] * v[1] - u[1] * v[0]);
			for (int i = 0; i < 3; i++) begin
				p = round14(u[i] * d);
				q = v[i] - p;
				outv[i] = p + round14(longint'(cos_q) * q) + round14(longint'(sin_q) * c[i]);
			end
		end else begin
			// short axis: translate only
			for (int i = 0; i < 3; i++)
				outv[i] = v[i];
		end
		for (int i = 0; i < 3; i++)
			outv[i] = clamp(outv[i] + sh[i], -64'sd2147483648, 64'sd2147483647);
		r.out_x = 32'(outv[0]);
		r.out_y = 32'(outv[1]);
		r.out_z = 32'(outv[2]);
		r.last_out = vi.last_vertex;
		return r;
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		vtx_out_t exp_r;
		if (!arst_n) begin
			q_w = 16'sd16384;
			q_x = 0;
			q_y = 0;
			q_z = 0;
			sh_x = 0;
			sh_y = 0;
			sh_z = 0;
			thr = 15'd16;
			rebuild_terms();
			expected_q.delete();
			fail_count <= 0;
		end else begin
			// apply a register write
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ROT_W:    q_w = cfg_wdata[15:0];
					REG_ROT_X:    q_x = cfg_wdata[15:0];
					REG_ROT_Y:    q_y = cfg_wdata[15:0];
					REG_ROT_Z:    q_z = cfg_wdata[15:0];
					REG_SHIFT_X:  sh_x = cfg_wdata;
					REG_SHIFT_Y:  sh_y = cfg_wdata;
					REG_SHIFT_Z:  sh_z = cfg_wdata;
					REG_AXIS_THR: thr = cfg_wdata[14:0];
					default: ;
				endcase
				rebuild_terms();
			end
			// compare an outgoing beat against the oldest prediction
			if (res_valid && !res_stall) begin
				if (expected_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result beat %h", res);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (exp_r !== res) begin
						if (fail_count < 10)
							$display("mismatch: exp x=%h y=%h z=%h l=%b got x=%h y=%h z=%h l=%b",
								exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.last_out,
								res.out_x, res.out_y, res.out_z, res.last_out);
						fail_count <= fail_count + 1;
					end
				end
			end
			// predict an incoming beat
			if (vtx_valid && !vtx_stall)
				expected_q.push_back(transform_vertex(vtx));
		end
	end

endmodule

// File: dv/quaternion_vertex_transform_unit_test.sv
`timescale 1ns / 100ps
// Top of the vertex transform testbench: clock, reset, stimulus and verdict.
// Depends on qvt_pkg, quaternion_vertex_transform_unit and qvt_checker.
module quaternion_vertex_transform_unit_test;
	import qvt_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_wdata;
	logic        vtx_valid;
	logic        vtx_stall;
	vtx_in_t     vtx;
	logic        res_valid;
	logic        res_stall;
	vtx_out_t    res;
	int          fail_count;
	int          pending;
	int          cycles;
	int          stall_left;
	bit          quiet;

	quaternion_vertex_transform_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	qvt_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.vtx_valid(vtx_valid), .vtx_stall(vtx_stall), .vtx(vtx),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: hold stall for a drawn number of cycles after each beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else if (res_valid && !res_stall) begin
			stall_left <= quiet ? 0 : $urandom_range(0, 14);
			res_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	task automatic wait_cycles(int n);
		repeat (n) @(posedge clk);
	endtask

	// drive one vertex beat; valid stays high when the next gap is zero
	task automatic send_vertex(vtx_in_t v);
		int gap;
		vtx_valid <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (vtx_stall);
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			wait_cycles(gap);
		end
	endtask

	// hold off until every predicted result is out, then let the pipe settle
	task automatic drain();
		vtx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		wait_cycles(12);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		while (vtx_stall)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_setting(logic [15:0] w, logic [15:0] x, logic [15:0] y,
		logic [15:0] z, logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
		logic [14:0] t);
		write_reg(REG_ROT_W, {{16{w[15]}}, w});
		write_reg(REG_ROT_X, {{16{x[15]}}, x});
		write_reg(REG_ROT_Y, {{16{y[15]}}, y});
		write_reg(REG_ROT_Z, {{16{z[15]}}, z});
		write_reg(REG_SHIFT_X, sx);
		write_reg(REG_SHIFT_Y, sy);
		write_reg(REG_SHIFT_Z, sz);
		write_reg(REG_AXIS_THR, {17'd0, t});
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2: return 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
			default: return 32'($signed($urandom_range(0, 32'h3ffffff)) - 32'sh2000000);
		endcase
	endfunction

	function automatic vtx_in_t pick_vertex();
		vtx_in_t v;
		v.vertex_x = pick_coord();
		v.vertex_y = pick_coord();
		v.vertex_z = pick_coord();
		v.last_vertex = $urandom_range(0, 1);
		return v;
	endfunction

	function automatic vtx_in_t mk_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic l);
		vtx_in_t v;
		v.vertex_x = x;
		v.vertex_y = y;
		v.vertex_z = z;
		v.last_vertex = l;
		return v;
	endfunction

	task automatic directed_set();
		send_vertex(mk_vertex(32'h7fffffff, 32'h80000000, 32'h00000000, 1'b0));
		send_vertex(mk_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1));
		send_vertex(mk_vertex(32'h00010000, 32'h00020000, 32'hfffd0000, 1'b0));
		send_vertex(mk_vertex(32'h00000000, 32'h00000000, 32'h00000000, 1'b1));
	endtask

	initial begin
		int n_items;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		vtx_valid = 1'b0;
		vtx = '0;
		cycles = 0;
		quiet = 1'b0;
		wait_cycles(10);
		arst_n <= 1'b1;
		wait_cycles(2);

		// directed: reset setting (translate only), then quarter turn about z
		directed_set();
		drain();
		load_setting(16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 32'h00010000, 32'hffff0000,
			32'h7fffffff, 15'd0);
		directed_set();
		drain();
		// scalar beyond one, full axis, saturating shift, threshold at max
		load_setting(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 32'h80000000, 32'h7fffffff,
			32'h0, 15'h7fff);
		directed_set();
		drain();
		load_setting(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 15'd0);
		directed_set();
		drain();
		// zero axis with threshold zero
		load_setting(16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0, 32'h0, 32'h0, 15'd0);
		directed_set();
		drain();

		// random phases with fresh settings
		for (int ph = 0; ph < 11; ph++) begin
			quiet = (ph % 4 == 1);
			load_setting($urandom_range(0, 1) ? 16'($urandom) :
					16'($signed($urandom_range(0, 32768)) - 16384),
				16'($signed($urandom_range(0, 32768)) - 16384),
				16'($signed($urandom_range(0, 32768)) - 16384),
				($urandom_range(0, 3) == 0) ? 16'($urandom) :
					16'($signed($urandom_range(0, 32768)) - 16384),
				($urandom_range(0, 2) == 0) ? $urandom :
					32'($signed($urandom_range(0, 32'hfffff)) - 32'sh80000),
				$urandom, 32'($signed($urandom_range(0, 32'hfffff)) - 32'sh80000),
				($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 64)));
			n_items = 60;
			for (int i = 0; i < n_items; i++)
				send_vertex(pick_vertex());
			drain();
		end
		quiet = 1'b0;

		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: quaternion_vertex_transform_unit.f
hw/rtl/qvt_pkg.sv
hw/rtl/qvt_derive.sv
hw/rtl/qvt_front.sv
hw/rtl/qvt_back.sv
hw/rtl/quaternion_vertex_transform_unit.sv
dv/qvt_checker.sv
dv/quaternion_vertex_transform_unit_test.sv
